// ----- rtl/qmn_pkg.sv -----
// ----------------------------------------------------------------------------
// qmn_pkg
// Types and constants shared by the quaternion multiply/normalize block.
// ----------------------------------------------------------------------------
`default_nettype none

package qmn_pkg;

  localparam int unsigned COMP_W = 16;
  localparam int unsigned THR_W  = 16;

  localparam logic [THR_W-1:0] THRESH_RESET = 16'd268;

  typedef struct packed {
    logic signed [COMP_W-1:0] a_x;
    logic signed [COMP_W-1:0] a_y;
    logic signed [COMP_W-1:0] a_z;
    logic signed [COMP_W-1:0] a_w;
    logic signed [COMP_W-1:0] b_x;
    logic signed [COMP_W-1:0] b_y;
    logic signed [COMP_W-1:0] b_z;
    logic signed [COMP_W-1:0] b_w;
  } operands_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] r_x;
    logic signed [COMP_W-1:0] r_y;
    logic signed [COMP_W-1:0] r_z;
    logic signed [COMP_W-1:0] r_w;
    logic                     near_zero;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/quaternion_multiply_normalize.sv -----
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Pipelined Hamilton product of two Q2.14 quaternions, normalized to unit
// length with exact round-to-nearest, or passed through saturated when the
// squared magnitude is at or below a programmable threshold.
// ----------------------------------------------------------------------------
// Usage:
//   - Input: a transaction is taken on each rising edge with start high and
//     busy low. busy is always low, so a new transaction may enter every
//     cycle; throughput is one item per clock.
//   - Output: done pulses for one cycle with the result on result. done
//     rises after the operand, product, sum, square, squared-magnitude,
//     seed, recurrence and output registers. The pipeline never stalls;
//     the receiver must take each result in its done cycle.
//   - The normalize step resolves one result bit per stage (FRAC_BITS + 1
//     stages) with a shift-add recurrence, so the depth is set by that chain.
//   - Config: cfg_data is written to zero_threshold when cfg_valid and
//     cfg_ready are high (cfg_ready is always high). Write only while idle.
//   - Reset (rst, synchronous): pipeline valids clear, threshold returns to
//     268. No results are in flight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_multiply_normalize #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire qmn_pkg::operands_t      operands,
  output logic                         done,
  output qmn_pkg::result_t             result,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [qmn_pkg::THR_W-1:0] cfg_data
);

  localparam int unsigned NC    = 4;
  localparam int unsigned PRD_W = 2 * qmn_pkg::COMP_W;      // one product
  localparam int unsigned P_W   = PRD_W + 2;                // signed sum of four
  localparam int unsigned M_W   = P_W - 1;                  // magnitude
  localparam int unsigned SQ_W  = 2 * M_W;
  localparam int unsigned S_W   = SQ_W + 2;
  localparam int unsigned RW    = S_W + 2 * FRAC_BITS + 6;  // recurrence width
  localparam int unsigned NST   = FRAC_BITS + 1;            // result bits
  localparam int unsigned RD_W  = FRAC_BITS + 1;
  localparam int unsigned U_W   = M_W + 1;

  logic [qmn_pkg::THR_W-1:0] zero_threshold;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= qmn_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      zero_threshold <= cfg_data;
    end
  end

  // Stage 0: operand register
  logic               v0;
  qmn_pkg::operands_t op0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= start && !busy;
    op0 <= operands;
  end

  // Stage 1: sixteen products
  logic                    v1;
  logic signed [PRD_W-1:0] prod1 [16];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
    prod1[0]  <= $signed(op0.a_w) * $signed(op0.b_x);
    prod1[1]  <= $signed(op0.a_x) * $signed(op0.b_w);
    prod1[2]  <= $signed(op0.a_y) * $signed(op0.b_z);
    prod1[3]  <= $signed(op0.a_z) * $signed(op0.b_y);
    prod1[4]  <= $signed(op0.a_w) * $signed(op0.b_y);
    prod1[5]  <= $signed(op0.a_x) * $signed(op0.b_z);
    prod1[6]  <= $signed(op0.a_y) * $signed(op0.b_w);
    prod1[7]  <= $signed(op0.a_z) * $signed(op0.b_x);
    prod1[8]  <= $signed(op0.a_w) * $signed(op0.b_z);
    prod1[9]  <= $signed(op0.a_x) * $signed(op0.b_y);
    prod1[10] <= $signed(op0.a_y) * $signed(op0.b_x);
    prod1[11] <= $signed(op0.a_z) * $signed(op0.b_w);
    prod1[12] <= $signed(op0.a_w) * $signed(op0.b_w);
    prod1[13] <= $signed(op0.a_x) * $signed(op0.b_x);
    prod1[14] <= $signed(op0.a_y) * $signed(op0.b_y);
    prod1[15] <= $signed(op0.a_z) * $signed(op0.b_z);
  end

  // Stage 2: component sums, split into sign and magnitude
  logic signed [P_W-1:0] psum [NC];
  logic                  v2;
  logic [M_W-1:0]        mag2 [NC];
  logic                  neg2 [NC];

  always_comb begin
    psum[0] = P_W'(prod1[0])  + P_W'(prod1[1])  + P_W'(prod1[2])  - P_W'(prod1[3]);
    psum[1] = P_W'(prod1[4])  - P_W'(prod1[5])  + P_W'(prod1[6])  + P_W'(prod1[7]);
    psum[2] = P_W'(prod1[8])  + P_W'(prod1[9])  - P_W'(prod1[10]) + P_W'(prod1[11]);
    psum[3] = P_W'(prod1[12]) - P_W'(prod1[13]) - P_W'(prod1[14]) - P_W'(prod1[15]);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    for (int c = 0; c < NC; c++) begin
      neg2[c] <= psum[c][P_W-1];
      mag2[c] <= psum[c][P_W-1] ? M_W'(-psum[c]) : M_W'(psum[c]);
    end
  end

  // Stage 3: squares
  logic            v3;
  logic [SQ_W-1:0] sq3  [NC];
  logic [M_W-1:0]  mag3 [NC];
  logic            neg3 [NC];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    for (int c = 0; c < NC; c++) begin
      sq3[c]  <= mag2[c] * mag2[c];
      mag3[c] <= mag2[c];
      neg3[c] <= neg2[c];
    end
  end

  // Stage 4: squared magnitude
  logic            v4;
  logic [S_W-1:0]  ssum4;
  logic [SQ_W-1:0] sq4  [NC];
  logic [M_W-1:0]  mag4 [NC];
  logic            neg4 [NC];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    ssum4 <= S_W'(sq3[0]) + S_W'(sq3[1]) + S_W'(sq3[2]) + S_W'(sq3[3]);
    for (int c = 0; c < NC; c++) begin
      sq4[c]  <= sq3[c];
      mag4[c] <= mag3[c];
      neg4[c] <= neg3[c];
    end
  end

  // Recurrence registers, index 0 is the init stage output.
  // rem = 4*m^2*2^(2F) - s*(2r-1)^2, qv = s*(2r-1), with r = 0 read as t = -1.
  logic                  vv    [NST+1];
  logic                  nearv [NST+1];
  logic signed [RW-1:0]  sv    [NST+1];
  logic signed [RW-1:0]  remv  [NST+1][NC];
  logic signed [RW-1:0]  qv    [NST+1][NC];
  logic [RD_W-1:0]       rv    [NST+1][NC];
  logic [M_W-1:0]        magv  [NST+1][NC];
  logic                  negv  [NST+1][NC];

  logic [RW-1:0] lim4;
  assign lim4 = RW'(zero_threshold) << (2 * FRAC_BITS);

  // Stage 5: near-zero test and recurrence seed
  always_ff @(posedge clk) begin
    if (rst) vv[0] <= 1'b0;
    else     vv[0] <= v4;
    nearv[0] <= RW'(ssum4) <= lim4;
    sv[0]    <= $signed(RW'(ssum4));
    for (int c = 0; c < NC; c++) begin
      remv[0][c] <= $signed(RW'(sq4[c]) << (2 * FRAC_BITS + 2)) - $signed(RW'(ssum4));
      qv[0][c]   <= -$signed(RW'(ssum4));
      rv[0][c]   <= '0;
      magv[0][c] <= mag4[c];
      negv[0][c] <= neg4[c];
    end
  end

  // One result bit per stage, most significant first
  for (genvar j = 0; j < NST; j++) begin : g_iter
    localparam int unsigned K = FRAC_BITS - j;

    logic signed [RW-1:0] cand [NC];

    always_comb begin
      for (int c = 0; c < NC; c++) begin
        cand[c] = remv[j][c] - (qv[j][c] <<< (K + 2)) - (sv[j] <<< (2 * K + 2));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vv[j+1] <= 1'b0;
      else     vv[j+1] <= vv[j];
      nearv[j+1] <= nearv[j];
      sv[j+1]    <= sv[j];
      for (int c = 0; c < NC; c++) begin
        magv[j+1][c] <= magv[j][c];
        negv[j+1][c] <= negv[j][c];
        if (!cand[c][RW-1]) begin
          remv[j+1][c] <= cand[c];
          qv[j+1][c]   <= qv[j][c] + (sv[j] <<< (K + 1));
          rv[j+1][c]   <= rv[j][c] | (RD_W'(1) << K);
        end else begin
          remv[j+1][c] <= remv[j][c];
          qv[j+1][c]   <= qv[j][c];
          rv[j+1][c]   <= rv[j][c];
        end
      end
    end
  end

  // Output stage: pick path, round, saturate
  logic [U_W-1:0]              umag [NC];
  logic [qmn_pkg::COMP_W-1:0]  comp [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (nearv[NST]) begin
        umag[c] = (U_W'(magv[NST][c]) + (U_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      end else begin
        umag[c] = U_W'(rv[NST][c]);
      end
      if (negv[NST][c]) begin
        comp[c] = (umag[c] >= U_W'(32768)) ? 16'h8000 : 16'(-umag[c]);
      end else begin
        comp[c] = (umag[c] >= U_W'(32767)) ? 16'h7FFF : umag[c][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vv[NST];
    result.r_x       <= comp[0];
    result.r_y       <= comp[1];
    result.r_z       <= comp[2];
    result.r_w       <= comp[3];
    result.near_zero <= nearv[NST];
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quaternion_multiply_normalize: random and corner
// quaternion pairs under several thresholds, results checked against an
// exact integer model of the normalized Hamilton product.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam int LAT = FRAC + 8;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  qmn_pkg::operands_t operands = '0;
  logic done;
  qmn_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qmn_pkg::THR_W-1:0] cfg_data = '0;

  quaternion_multiply_normalize #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operands(operands),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  qmn_pkg::operands_t pending_ops[$];
  qmn_pkg::result_t expected_products[$];
  logic [qmn_pkg::THR_W-1:0] threshold = qmn_pkg::THRESH_RESET;
  int send_idle_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  logic busy_q = 1'b0;

  // Largest r in [0, 2^FRAC] with (2r-1)^2 * s <= 4 * m^2 * 2^(2*FRAC)
  function automatic logic [15:0] unit_magnitude(logic [63:0] m, logic [127:0] s);
    logic [127:0] rhs;
    logic [63:0] lo, hi, mid, t;
    rhs = (128'(m) * m) << (2 * FRAC + 2);
    lo = 0;
    hi = 64'd1 << FRAC;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 2 * mid - 1;
      if (s * 128'(t * t) <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic logic [15:0] clamp_q(logic [63:0] m, logic neg);
    if (neg) return (m >= 32768) ? 16'h8000 : 16'(-$signed({1'b0, m}));
    return (m >= 32767) ? 16'h7fff : m[15:0];
  endfunction

  function automatic qmn_pkg::result_t hamilton_normalized(qmn_pkg::operands_t o,
                                                           logic [qmn_pkg::THR_W-1:0] thr);
    longint p[4];
    logic [63:0] m;
    logic [127:0] s;
    logic near;
    logic [63:0] r;
    logic [15:0] c[4];
    qmn_pkg::result_t res;
    longint ax, ay, az, aw, bx, by, bz, bw;
    ax = o.a_x; ay = o.a_y; az = o.a_z; aw = o.a_w;
    bx = o.b_x; by = o.b_y; bz = o.b_z; bw = o.b_w;
    p[0] = aw * bx + ax * bw + ay * bz - az * by;
    p[1] = aw * by - ax * bz + ay * bw + az * bx;
    p[2] = aw * bz + ax * by - ay * bx + az * bw;
    p[3] = aw * bw - ax * bx - ay * by - az * bz;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m = (p[i] < 0) ? -p[i] : p[i];
      s += 128'(m) * m;
    end
    near = (s <= (128'(thr) << (2 * FRAC)));
    for (int i = 0; i < 4; i++) begin
      m = (p[i] < 0) ? -p[i] : p[i];
      if (near) r = (m + (64'd1 << (FRAC - 1))) >> FRAC;
      else r = 64'(unit_magnitude(m, s));
      c[i] = clamp_q(r, p[i] < 0);
    end
    res.r_x = c[0]; res.r_y = c[1]; res.r_z = c[2]; res.r_w = c[3];
    res.near_zero = near;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_q) begin
      // previous transaction taken at this rising edge; pick next
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        operands <= pending_ops.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        operands <= pending_ops.pop_front();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    busy_q <= busy;
    if (!rst && start && !busy)
      expected_products.push_back(hamilton_normalized(operands, threshold));
    if (!rst && cfg_valid && cfg_ready) threshold <= cfg_data;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (expected_products.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          qmn_pkg::result_t want;
          want = expected_products.pop_front();
          if (result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected x=%0d y=%0d z=%0d w=%0d nz=%b, ",
                        "got x=%0d y=%0d z=%0d w=%0d nz=%b"},
                       want.r_x, want.r_y, want.r_z, want.r_w, want.near_zero,
                       result.r_x, result.r_y, result.r_z, result.r_w, result.near_zero);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic qmn_pkg::operands_t random_pair();
    qmn_pkg::operands_t o;
    int mode;
    mode = $urandom_range(9);
    mode = (mode < 4) ? 0 : (mode < 7) ? 3 : (mode < 9) ? 1 : 2;
    o.a_x = rand_comp(mode); o.a_y = rand_comp(mode);
    o.a_z = rand_comp(mode); o.a_w = rand_comp(mode);
    o.b_x = rand_comp(mode); o.b_y = rand_comp(mode);
    o.b_z = rand_comp(mode); o.b_w = rand_comp(mode);
    if ($urandom_range(15) == 0) o.b_x = 0;
    return o;
  endfunction

  task automatic drain();
    while (pending_ops.size() > 0 || start || expected_products.size() > 0)
      @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [qmn_pkg::THR_W-1:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int count, int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) pending_ops.push_back(random_pair());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, identity, extremes, tiny products below the threshold
    send_idle_pct = 0;
    pending_ops.push_back('0);
    pending_ops.push_back('{0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
    pending_ops.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_ops.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                            16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_ops.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    pending_ops.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0});
    pending_ops.push_back('{0, 0, 0, 16'sd16, 0, 0, 0, 16'sd16});
    pending_ops.push_back('{0, 0, 0, 16'sd16, 0, 0, 0, 16'sd17});
    pending_ops.push_back('{0, 0, 0, 16'sd1, 0, 0, 0, 16'sd268});
    pending_ops.push_back('{0, 0, 0, 16'sd1, 0, 0, 0, 16'sd269});
    pending_ops.push_back('{0, 0, 0, -16'sd1, 0, 0, 0, 16'sd8192});
    pending_ops.push_back('{16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7, 16'sd8});
    pending_ops.push_back('{-16'sd3, 16'sd1, -16'sd2, 16'sd5, 16'sd4, -16'sd7, 16'sd2, -16'sd1});
    pending_ops.push_back('{0, 16'sd16384, 0, 0, 16'sd16384, 0, 0, 0});
    pending_ops.push_back('{16'sd8192, 0, 0, 16'sd8192, 0, 16'sd8192, 16'sd8192, 0});
    drain();

    write_threshold(16'd0);
    pending_ops.push_back('0);
    pending_ops.push_back('{0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1});
    pending_ops.push_back('{0, 0, 0, -16'sd1, 0, 0, 0, 16'sd1});
    drain();
    write_threshold(16'hffff);
    pending_ops.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
    pending_ops.push_back('{0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
    pending_ops.push_back('{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0});
    drain();

    write_threshold(qmn_pkg::THRESH_RESET);
    run_random(700, 26);
    write_threshold(16'($urandom));
    run_random(650, 68);
    write_threshold(16'hffff);
    run_random(300, 0);
    write_threshold(16'd0);
    run_random(350, 0);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/qmn_pkg.sv
rtl/quaternion_multiply_normalize.sv
bench/testbench.sv
